>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("gmc assertion failed");

// Same check, sampled only when a result beat is on the output.
`define ASSERT_ON_VALID(label, clk, rst_n, vld, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (vld) |-> (prop)) \
        else $error("gmc assertion failed on output beat");

`endif

>>> sv/gmc_pkg.sv
// Package: payload types and codes of the gate motor controller.
`timescale 1ns / 1ps
package gmc_pkg;

    localparam int CNT_W = 16;

    // motion codes
    localparam logic [1:0] MOT_STOP  = 2'd0;
    localparam logic [1:0] MOT_CLOSE = 2'd1;
    localparam logic [1:0] MOT_OPEN  = 2'd2;

    // key event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_STOP  = 2'd1;
    localparam logic [1:0] EV_CLOSE = 2'd2;
    localparam logic [1:0] EV_OPEN  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_THRESHOLD    = 2'd0;
    localparam logic [1:0] CFG_SENSOR_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_STOP_HOLD_TICKS  = 2'd2;

    localparam logic [CNT_W-1:0] KEY_THRESHOLD_RST    = 16'd5;
    localparam logic [CNT_W-1:0] SENSOR_THRESHOLD_RST = 16'd10;
    localparam logic [CNT_W-1:0] STOP_HOLD_TICKS_RST  = 16'd10;

    typedef struct packed {
        logic stop_button;
        logic close_button;
        logic open_button;
        logic closed_limit;
        logic opened_limit;
    } gmc_in_t;

    typedef struct packed {
        logic       close_drive;
        logic       open_drive;
        logic [1:0] motion;
        logic [1:0] key_event;
        logic       holding;
    } gmc_out_t;

endpackage

>>> sv/gmc_key_filter.sv
// Button debounce: priority select and shared hold counter, one event per hold unless the threshold is all ones.
`timescale 1ns / 1ps
module gmc_key_filter (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     tick_en,
    input  gmc_pkg::gmc_in_t         in_data,
    input  logic [gmc_pkg::CNT_W-1:0] key_threshold,
    output logic [1:0]               key_event
);

    logic [gmc_pkg::CNT_W-1:0] key_count_reg;
    logic [gmc_pkg::CNT_W-1:0] key_count_next;
    logic [1:0]                key_sel;

    always_comb begin
        if (in_data.stop_button) begin
            key_sel = gmc_pkg::EV_STOP;
        end else if (in_data.close_button) begin
            key_sel = gmc_pkg::EV_CLOSE;
        end else if (in_data.open_button) begin
            key_sel = gmc_pkg::EV_OPEN;
        end else begin
            key_sel = gmc_pkg::EV_NONE;
        end
    end

    always_comb begin
        key_event      = gmc_pkg::EV_NONE;
        key_count_next = key_count_reg;
        if (key_sel != gmc_pkg::EV_NONE) begin
            if (key_count_reg == key_threshold) begin
                key_event = key_sel;
            end
            // stops counting past the threshold, saturates at all ones
            if (key_count_reg <= key_threshold && key_count_reg != '1) begin
                key_count_next = key_count_reg + 1'b1;
            end
        end else begin
            key_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg <= '0;
        end else if (tick_en) begin
            key_count_reg <= key_count_next;
        end
    end

endmodule

>>> sv/gmc_limit_counter.sv
// Limit switch counter: fires at the threshold, then repeats while held.
`timescale 1ns / 1ps
module gmc_limit_counter #(
    parameter int REPEAT_STEP = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     tick_en,
    input  logic                     active,
    input  logic [gmc_pkg::CNT_W-1:0] sensor_threshold,
    output logic                     fire
);

    localparam logic [gmc_pkg::CNT_W-1:0] STEP = gmc_pkg::CNT_W'(REPEAT_STEP);

    logic [gmc_pkg::CNT_W-1:0] count_reg;
    logic [gmc_pkg::CNT_W-1:0] count_next;

    always_comb begin
        fire       = 1'b0;
        count_next = count_reg;
        if (!active) begin
            count_next = '0;
        end else if (count_reg >= sensor_threshold) begin
            fire = 1'b1;
            // drop back one step, floor at zero
            count_next = (count_reg >= STEP) ? count_reg - STEP : '0;
        end else begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (tick_en) begin
            count_reg <= count_next;
        end
    end

endmodule

>>> sv/gate_motor_controller_unit.sv
// Each accepted input beat's result beat is registered onto m_ in the next cycle.
// Throughput: one beat per cycle; all tick logic is one combinational pass into
// the state and result registers, and s_ready holds unless a result is stalled.
// Reset (aresetn low, synchronous): motion stopped, counters and hold cleared,
// registers back to key 5, sensor 10, hold 10, no result pending.
`timescale 1ns / 1ps
module gate_motor_controller_unit #(
    parameter int REPEAT_STEP = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [gmc_pkg::CNT_W-1:0] cfg_data,
    // input ticks
    input  logic                      s_valid,
    output logic                      s_ready,
    input  gmc_pkg::gmc_in_t          s_data,
    // results
    output logic                      m_valid,
    input  logic                      m_ready,
    output gmc_pkg::gmc_out_t         m_data
);

    logic [gmc_pkg::CNT_W-1:0] key_threshold_reg;
    logic [gmc_pkg::CNT_W-1:0] sensor_threshold_reg;
    logic [gmc_pkg::CNT_W-1:0] stop_hold_ticks_reg;

    logic [1:0]                motion_reg;
    logic [1:0]                motion_next;
    logic [gmc_pkg::CNT_W-1:0] hold_reg;
    logic [gmc_pkg::CNT_W-1:0] hold_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    gmc_pkg::gmc_out_t         m_data_reg;
    gmc_pkg::gmc_out_t         m_data_next;

    logic       beat;
    logic       hold_active;
    logic       run_en;
    logic [1:0] key_event;
    logic       fire_closed;
    logic       fire_opened;
    logic [1:0] motion_mid;
    logic       do_stop;

    assign cfg_ready   = 1'b1;
    assign s_ready     = !m_valid_reg || m_ready;
    assign beat        = s_valid && s_ready;
    assign hold_active = (hold_reg != '0);
    assign run_en      = beat && !hold_active;

    gmc_key_filter u_key (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tick_en       (run_en),
        .in_data       (s_data),
        .key_threshold (key_threshold_reg),
        .key_event     (key_event)
    );

    gmc_limit_counter #(.REPEAT_STEP(REPEAT_STEP)) u_closed (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .tick_en          (run_en),
        .active           (s_data.closed_limit),
        .sensor_threshold (sensor_threshold_reg),
        .fire             (fire_closed)
    );

    gmc_limit_counter #(.REPEAT_STEP(REPEAT_STEP)) u_opened (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .tick_en          (run_en),
        .active           (s_data.opened_limit),
        .sensor_threshold (sensor_threshold_reg),
        .fire             (fire_opened)
    );

    // motion rules: key first, then closed limit, then opened limit
    always_comb begin
        motion_mid = motion_reg;
        do_stop    = 1'b0;
        case (key_event)
            gmc_pkg::EV_STOP: begin
                motion_mid = gmc_pkg::MOT_STOP;
                do_stop    = 1'b1;
            end
            gmc_pkg::EV_CLOSE: begin
                if (motion_reg == gmc_pkg::MOT_OPEN) begin
                    motion_mid = gmc_pkg::MOT_STOP;
                    do_stop    = 1'b1;
                end else begin
                    motion_mid = gmc_pkg::MOT_CLOSE;
                end
            end
            gmc_pkg::EV_OPEN: begin
                if (motion_reg == gmc_pkg::MOT_CLOSE) begin
                    motion_mid = gmc_pkg::MOT_STOP;
                    do_stop    = 1'b1;
                end else begin
                    motion_mid = gmc_pkg::MOT_OPEN;
                end
            end
            default: begin
            end
        endcase
        if (fire_closed && motion_mid == gmc_pkg::MOT_CLOSE) begin
            motion_mid = gmc_pkg::MOT_STOP;
            do_stop    = 1'b1;
        end
        if (fire_opened && motion_mid == gmc_pkg::MOT_OPEN) begin
            motion_mid = gmc_pkg::MOT_STOP;
            do_stop    = 1'b1;
        end
    end

    always_comb begin
        motion_next = motion_reg;
        hold_next   = hold_reg;
        if (beat) begin
            if (hold_active) begin
                hold_next = hold_reg - 1'b1;
            end else begin
                motion_next = motion_mid;
                if (do_stop) begin
                    hold_next = stop_hold_ticks_reg;
                end
            end
        end
    end

    always_comb begin
        m_data_next.close_drive = (motion_next == gmc_pkg::MOT_CLOSE);
        m_data_next.open_drive  = (motion_next == gmc_pkg::MOT_OPEN);
        m_data_next.motion      = motion_next;
        m_data_next.key_event   = hold_active ? gmc_pkg::EV_NONE : key_event;
        m_data_next.holding     = hold_active;
    end

    always_comb begin
        if (beat) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motion_reg  <= gmc_pkg::MOT_STOP;
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            motion_reg  <= motion_next;
            hold_reg    <= hold_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_threshold_reg    <= gmc_pkg::KEY_THRESHOLD_RST;
            sensor_threshold_reg <= gmc_pkg::SENSOR_THRESHOLD_RST;
            stop_hold_ticks_reg  <= gmc_pkg::STOP_HOLD_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                gmc_pkg::CFG_KEY_THRESHOLD:    key_threshold_reg    <= cfg_data;
                gmc_pkg::CFG_SENSOR_THRESHOLD: sensor_threshold_reg <= cfg_data;
                gmc_pkg::CFG_STOP_HOLD_TICKS:  stop_hold_ticks_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> sv/gmc_checker.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gmc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input gmc_pkg::gmc_out_t m_data
);

    // a held tick never reports a key
    `ASSERT_ON_VALID(a_hold_no_key, aclk, aresetn, m_valid, (!m_data.holding || m_data.key_event == gmc_pkg::EV_NONE))

    // drives decode the motion field
    `ASSERT_ON_VALID(a_drive_decode, aclk, aresetn, m_valid, (m_data.close_drive == (m_data.motion == gmc_pkg::MOT_CLOSE) && m_data.open_drive == (m_data.motion == gmc_pkg::MOT_OPEN)))

    // a stop key always leaves the gate stopped
    `ASSERT_ON_VALID(a_stop_key_stops, aclk, aresetn, m_valid, (m_data.key_event != gmc_pkg::EV_STOP || m_data.motion == gmc_pkg::MOT_STOP))

    // a stalled result beat stays on the port
    `ASSERT_CLK(a_valid_holds, aclk, aresetn, (m_valid && !m_ready) |=> m_valid)

endmodule

bind gate_motor_controller_unit gmc_checker u_gmc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> bench/tb_gate_motor_controller_unit.sv
// Testbench for the gate motor controller: directed and random ticks checked against a predictor.
`timescale 1ns / 1ps
module tb_gate_motor_controller_unit;

    localparam int REPEAT_STEP = 10;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [1:0]                cfg_index = gmc_pkg::CFG_KEY_THRESHOLD;
    logic [gmc_pkg::CNT_W-1:0] cfg_data  = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    gmc_pkg::gmc_in_t          s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    gmc_pkg::gmc_out_t         m_data;

    // predictor copy of registers and state
    logic [gmc_pkg::CNT_W-1:0] key_thr    = gmc_pkg::KEY_THRESHOLD_RST;
    logic [gmc_pkg::CNT_W-1:0] sen_thr    = gmc_pkg::SENSOR_THRESHOLD_RST;
    logic [gmc_pkg::CNT_W-1:0] hold_len   = gmc_pkg::STOP_HOLD_TICKS_RST;
    logic [1:0]                motion     = gmc_pkg::MOT_STOP;
    logic [gmc_pkg::CNT_W-1:0] key_cnt    = '0;
    logic [gmc_pkg::CNT_W-1:0] closed_cnt = '0;
    logic [gmc_pkg::CNT_W-1:0] opened_cnt = '0;
    logic [gmc_pkg::CNT_W-1:0] hold_cnt   = '0;

    gmc_pkg::gmc_out_t pending_drive[$];
    int                live_ticks  = 0;
    int                mismatches  = 0;
    int                cycle_count = 0;
    bit                no_idle     = 1'b0;

    gate_motor_controller_unit #(
        .REPEAT_STEP(REPEAT_STEP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // {fires, next count} of one limit switch counter
    function automatic logic [16:0] limit_step(input logic [gmc_pkg::CNT_W-1:0] cnt,
                                               input logic active);
        if (!active) return {1'b0, 16'd0};
        if (cnt >= sen_thr)
            return {1'b1, (cnt >= REPEAT_STEP) ? cnt - 16'(REPEAT_STEP) : 16'd0};
        return {1'b0, cnt + 16'd1};
    endfunction

    function automatic void stop_gate();
        motion   = gmc_pkg::MOT_STOP;
        hold_cnt = hold_len;
    endfunction

    function automatic gmc_pkg::gmc_out_t predict_drive(input gmc_pkg::gmc_in_t t);
        logic [1:0]        key;
        logic [1:0]        ev;
        logic              held;
        logic              fire_cl;
        logic              fire_op;
        gmc_pkg::gmc_out_t r;
        key  = gmc_pkg::EV_NONE;
        ev   = gmc_pkg::EV_NONE;
        held = 1'b0;
        if (hold_cnt != 0) begin
            hold_cnt = hold_cnt - 16'd1;
            held     = 1'b1;
        end else begin
            live_ticks++;
            if (t.stop_button) key = gmc_pkg::EV_STOP;
            else if (t.close_button) key = gmc_pkg::EV_CLOSE;
            else if (t.open_button) key = gmc_pkg::EV_OPEN;
            if (key != gmc_pkg::EV_NONE) begin
                if (key_cnt == key_thr) ev = key;
                if (key_cnt <= key_thr && key_cnt != 16'hFFFF) key_cnt = key_cnt + 16'd1;
            end else begin
                key_cnt = '0;
            end
            {fire_cl, closed_cnt} = limit_step(closed_cnt, t.closed_limit);
            {fire_op, opened_cnt} = limit_step(opened_cnt, t.opened_limit);
            case (ev)
                gmc_pkg::EV_STOP: stop_gate();
                gmc_pkg::EV_CLOSE: begin
                    if (motion == gmc_pkg::MOT_OPEN) stop_gate();
                    else motion = gmc_pkg::MOT_CLOSE;
                end
                gmc_pkg::EV_OPEN: begin
                    if (motion == gmc_pkg::MOT_CLOSE) stop_gate();
                    else motion = gmc_pkg::MOT_OPEN;
                end
                default: ;
            endcase
            if (fire_cl && motion == gmc_pkg::MOT_CLOSE) stop_gate();
            if (fire_op && motion == gmc_pkg::MOT_OPEN) stop_gate();
        end
        r.close_drive = (motion == gmc_pkg::MOT_CLOSE);
        r.open_drive  = (motion == gmc_pkg::MOT_OPEN);
        r.motion      = motion;
        r.key_event   = ev;
        r.holding     = held;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : check_beat
        gmc_pkg::gmc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_drive.size() == 0) begin
                $error("result beat with nothing pending: %b", m_data);
                mismatches++;
            end else begin
                want = pending_drive.pop_front();
                check_field("close_drive", want.close_drive, m_data.close_drive);
                check_field("open_drive", want.open_drive, m_data.open_drive);
                check_field("motion", want.motion, m_data.motion);
                check_field("key_event", want.key_event, m_data.key_event);
                check_field("holding", want.holding, m_data.holding);
            end
        end
    end

    initial begin : sink_pacing
        int run_len;
        int stall_len;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            run_len = no_idle ? 1 : $urandom_range(1, 12);
            repeat (run_len) @(posedge aclk);
            stall_len = pick_gap();
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    // valid is left high after the beat; the next call or wait_idle decides
    task automatic send_tick(input gmc_pkg::gmc_in_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        pending_drive.push_back(predict_drive(t));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [gmc_pkg::CNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            gmc_pkg::CFG_KEY_THRESHOLD:    key_thr  = val;
            gmc_pkg::CFG_SENSOR_THRESHOLD: sen_thr  = val;
            gmc_pkg::CFG_STOP_HOLD_TICKS:  hold_len = val;
            default: ;
        endcase
    endtask

    // the write to the unused index must leave all three registers alone
    task automatic set_config(input logic [gmc_pkg::CNT_W-1:0] k,
                              input logic [gmc_pkg::CNT_W-1:0] s,
                              input logic [gmc_pkg::CNT_W-1:0] h);
        wait_idle();
        write_reg(gmc_pkg::CFG_KEY_THRESHOLD, k);
        write_reg(gmc_pkg::CFG_SENSOR_THRESHOLD, s);
        write_reg(gmc_pkg::CFG_STOP_HOLD_TICKS, h);
        write_reg(CFG_UNUSED, 16'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_ticks(input int n);
        int         target;
        int         kind;
        int         len;
        int         i;
        logic [2:0] keys;
        logic [1:0] lims;
        target = live_ticks + n;
        while (live_ticks < target) begin
            kind = $urandom_range(0, 9);
            keys = '0;
            lims = '0;
            if (kind < 4) begin
                case ($urandom_range(0, 3))
                    0: keys = 3'b100;
                    1: keys = 3'b010;
                    2: keys = 3'b001;
                    default: keys = 3'($urandom_range(1, 7));
                endcase
                if ($urandom_range(0, 3) == 0) lims = 2'($urandom());
                len = $urandom_range(1, key_thr + 4);
            end else if (kind < 7) begin
                lims = $urandom_range(0, 1) ? 2'b10 : 2'b01;
                if ($urandom_range(0, 5) == 0) lims = 2'b11;
                len = $urandom_range(1, sen_thr + 2 * REPEAT_STEP + 4);
            end else begin
                len = $urandom_range(1, 4);
            end
            for (i = 0; i < len; i++) begin
                if (kind == 9)
                    send_tick(gmc_pkg::gmc_in_t'(5'($urandom())));
                else if ($urandom_range(0, 15) == 0)
                    send_tick(gmc_pkg::gmc_in_t'({keys, lims} ^ (5'd1 << $urandom_range(0, 4))));
                else
                    send_tick(gmc_pkg::gmc_in_t'({keys, lims}));
            end
        end
    endtask

    // tick layout: {stop, close, open, closed_limit, opened_limit}
    task automatic test_key_priority();
        // reset key threshold: close fires on its sixth tick
        repeat (6) send_tick(gmc_pkg::gmc_in_t'(5'b010_00));
        send_tick(gmc_pkg::gmc_in_t'(5'b000_00));
        set_config(16'd0, 16'd10, 16'd2);
        send_tick(gmc_pkg::gmc_in_t'(5'b111_11));      // stop wins, hold starts
        repeat (2) send_tick(gmc_pkg::gmc_in_t'(5'b111_11));
        send_tick(gmc_pkg::gmc_in_t'(5'b000_00));
        send_tick(gmc_pkg::gmc_in_t'(5'b010_00));      // closing
        send_tick(gmc_pkg::gmc_in_t'(5'b000_00));
        send_tick(gmc_pkg::gmc_in_t'(5'b011_00));      // close beats open
        send_tick(gmc_pkg::gmc_in_t'(5'b000_00));
        send_tick(gmc_pkg::gmc_in_t'(5'b001_00));      // open while closing stops
        repeat (3) send_tick(gmc_pkg::gmc_in_t'(5'b000_00));
        send_tick(gmc_pkg::gmc_in_t'(5'b001_00));      // opening
        send_tick(gmc_pkg::gmc_in_t'(5'b000_00));
        send_tick(gmc_pkg::gmc_in_t'(5'b010_00));      // close while opening stops
        repeat (3) send_tick(gmc_pkg::gmc_in_t'(5'b000_00));
        send_tick(gmc_pkg::gmc_in_t'(5'b100_00));      // stop while stopped still holds
        repeat (3) send_tick(gmc_pkg::gmc_in_t'(5'b000_00));
        repeat (3) send_tick(gmc_pkg::gmc_in_t'(5'b010_00));  // one event per hold
    endtask

    task automatic test_limit_stops();
        // sensor threshold under the repeat step, no stop hold
        set_config(16'd0, 16'd0, 16'd0);
        send_tick(gmc_pkg::gmc_in_t'(5'b000_00));
        send_tick(gmc_pkg::gmc_in_t'(5'b010_00));
        send_tick(gmc_pkg::gmc_in_t'(5'b000_10));
        send_tick(gmc_pkg::gmc_in_t'(5'b001_00));
        send_tick(gmc_pkg::gmc_in_t'(5'b000_10));      // wrong direction, keeps opening
        send_tick(gmc_pkg::gmc_in_t'(5'b000_01));
        send_tick(gmc_pkg::gmc_in_t'(5'b000_11));
    endtask

    task automatic test_threshold_lowered();
        set_config(16'd5, 16'd10, 16'd0);
        repeat (3) send_tick(gmc_pkg::gmc_in_t'(5'b010_00));
        set_config(16'd1, 16'd10, 16'd0);
        // count already past the new threshold: silent until release
        repeat (2) send_tick(gmc_pkg::gmc_in_t'(5'b010_00));
        send_tick(gmc_pkg::gmc_in_t'(5'b000_00));
        repeat (2) send_tick(gmc_pkg::gmc_in_t'(5'b010_00));
    endtask

    task automatic test_random_phases();
        set_config(gmc_pkg::KEY_THRESHOLD_RST, gmc_pkg::SENSOR_THRESHOLD_RST,
                   gmc_pkg::STOP_HOLD_TICKS_RST);
        run_random_ticks(180);
        set_config(16'd0, 16'd10, 16'd0);
        run_random_ticks(180);
        no_idle = 1'b1;
        set_config(16'd1, 16'd12, 16'd3);
        run_random_ticks(180);
        no_idle = 1'b0;
        set_config(16'd2, 16'd3, 16'd1);
        run_random_ticks(180);
        repeat (2) begin
            set_config(16'($urandom_range(0, 4)), 16'($urandom_range(10, 20)),
                       16'($urandom_range(0, 6)));
            run_random_ticks(180);
        end
    endtask

    task automatic test_register_extremes();
        int i;
        no_idle = 1'b1;
        set_config(16'd65534, 16'd65535, 16'd65535);
        // top thresholds: a short run fires neither a key nor a limit
        repeat (30) send_tick(gmc_pkg::gmc_in_t'(5'b010_10));
        for (i = 0; i < 20; i++) send_tick(gmc_pkg::gmc_in_t'(5'($urandom())));
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_key_priority();
        test_limit_stops();
        test_threshold_lowered();
        test_random_phases();
        test_register_extremes();
        wait_idle();
        repeat (5) @(posedge aclk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/gmc_pkg.sv
sv/gmc_key_filter.sv
sv/gmc_limit_counter.sv
sv/gate_motor_controller_unit.sv
sv/gmc_checker.sv
bench/tb_gate_motor_controller_unit.sv
